// ===== sv/modexp_pkg.sv =====
package modexp_pkg;

    // width of the fields on the ports
    localparam int FIELD_W = 32;
    // width of the internal datapath
    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WIDTH - 1);

    typedef logic [WIDTH-1:0] data_t;
    // modulus with one extra bit, so a zero register means 2^WIDTH
    typedef logic [WIDTH:0] mod_t;

    localparam data_t DATA_ONE = data_t'(1);

    // launch of one modular product
    typedef struct packed {
        logic  start;
        data_t op_a;
        data_t op_b;
    } mul_req_t;

    // completion of one modular product
    typedef struct packed {
        logic  done;
        data_t prod;
    } mul_rsp_t;

endpackage

// ===== sv/modexp_modmul.sv =====
module modexp_modmul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  modexp_pkg::mod_t      modulus,
    input  modexp_pkg::mul_req_t  req,
    output modexp_pkg::mul_rsp_t  rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [modexp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    modexp_pkg::data_t             acc_reg, acc_next;
    modexp_pkg::data_t             a_reg, a_next;
    modexp_pkg::data_t             b_reg, b_next;

    logic [modexp_pkg::WIDTH+1:0]  sum;
    logic [modexp_pkg::WIDTH+2:0]  diff_one;
    logic [modexp_pkg::WIDTH+2:0]  diff_two;
    modexp_pkg::data_t             step_val;

    // one multiplier bit per cycle: acc = 2*acc + bit*a, reduced by 0, m or 2m
    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0}
            + (b_reg[modexp_pkg::WIDTH-1] ? {2'b00, a_reg} : '0);
        diff_one = {1'b0, sum} - {2'b00, modulus};
        diff_two = {1'b0, sum} - {1'b0, modulus, 1'b0};
        if (!diff_two[modexp_pkg::WIDTH+2])
        begin
            step_val = diff_two[modexp_pkg::WIDTH-1:0];
        end
        else if (!diff_one[modexp_pkg::WIDTH+2])
        begin
            step_val = diff_one[modexp_pkg::WIDTH-1:0];
        end
        else
        begin
            step_val = sum[modexp_pkg::WIDTH-1:0];
        end
    end

    // operand load and bit sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (busy_reg)
        begin
            acc_next = step_val;
            b_next   = b_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            acc_next  = '0;
            a_next    = req.op_a;
            b_next    = req.op_b;
            cnt_next  = modexp_pkg::LAST_BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

// ===== sv/modular_exponentiation.sv =====
// channel   | dir | signals                        | contents
// s_axis    | in  | s_tvalid s_tready s_tdata[63:0] | base_value, exponent
// m_axis    | out | m_tvalid m_tready m_tdata[31:0] | power_result
// config    | in  | cfg_we cfg_wdata[31:0]          | modulus
//
// each modular product runs through the bit-serial multiplier
// an item needs a reduction of the base, a square per exponent bit and a multiply per one bit; zero exponent none
// the multiplier is the only arithmetic unit and runs one product at a time
// reset sets the modulus to 2 and empties the output register
// a finished result waits in the output register; the next item is taken meanwhile
module modular_exponentiation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // base_value [31:0], exponent [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // power_result [31:0]
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_SQUARE = 5'b00100,
        ST_MULT   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [31:0]                   mod_reg;
    modexp_pkg::data_t             r_reg, r_next;
    modexp_pkg::data_t             b_reg, b_next;
    modexp_pkg::data_t             e_reg, e_next;
    logic [modexp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [31:0]                   out_data_reg, out_data_next;

    modexp_pkg::data_t             in_base;
    modexp_pkg::data_t             in_exp;
    modexp_pkg::data_t             mod_w;
    modexp_pkg::mod_t              mod_ext;
    modexp_pkg::data_t             r_init;
    modexp_pkg::mul_req_t          req;
    modexp_pkg::mul_rsp_t          rsp;
    logic                          next_bit;

    assign in_base = modexp_pkg::data_t'(s_tdata[31:0]);
    assign in_exp  = modexp_pkg::data_t'(s_tdata[63:32]);
    assign mod_w   = modexp_pkg::data_t'(mod_reg);
    // a zero modulus stands for 2^WIDTH
    assign mod_ext = {(mod_w == '0), mod_w};
    assign r_init  = (mod_w == modexp_pkg::DATA_ONE) ? '0 : modexp_pkg::DATA_ONE;

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= 32'd2;
        end
        else if (cfg_we)
        begin
            mod_reg <= cfg_wdata;
        end
    end

    modexp_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (mod_ext),
        .req     (req),
        .rsp     (rsp)
    );

    // square-and-multiply sequencer, exponent shifted out msb first
    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        req.start      = 1'b0;
        req.op_a       = rsp.prod;
        req.op_b       = rsp.prod;
        next_bit       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    e_next   = in_exp;
                    cnt_next = modexp_pkg::LAST_BIT;
                    if (in_exp == '0)
                    begin
                        r_next     = modexp_pkg::DATA_ONE;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // base mod m as the product 1 * base
                        req.start  = 1'b1;
                        req.op_a   = modexp_pkg::DATA_ONE;
                        req.op_b   = in_base;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (rsp.done)
                begin
                    b_next     = rsp.prod;
                    req.start  = 1'b1;
                    req.op_a   = r_init;
                    req.op_b   = r_init;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (rsp.done)
                begin
                    r_next = rsp.prod;
                    if (e_reg[modexp_pkg::WIDTH-1])
                    begin
                        req.start  = 1'b1;
                        req.op_b   = b_reg;
                        state_next = ST_MULT;
                    end
                    else
                    begin
                        next_bit = 1'b1;
                    end
                end
            end
            ST_MULT:
            begin
                if (rsp.done)
                begin
                    r_next   = rsp.prod;
                    next_bit = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = 32'(r_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // move on to the next exponent bit
        if (next_bit)
        begin
            e_next   = e_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                state_next = ST_DONE;
            end
            else
            begin
                req.start  = 1'b1;
                req.op_a   = rsp.prod;
                req.op_b   = rsp.prod;
                state_next = ST_SQUARE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        b_reg        <= b_next;
        e_reg        <= e_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sv/modexp_checker.sv =====
module modexp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a result is held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // one item at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a new result comes out as the block returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while still busy");

    // zero exponent gives 1 via the done state and the output register when the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[63:32] == 32'd0) && !m_tvalid
        |-> ##2 (m_tvalid && (m_tdata == 32'd1)))
        else $error("zero exponent did not give 1");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);
